// ----- design/ptq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FIELD5_W    = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] CFG_KIND_FIRST  = 2'd0;
    localparam logic [1:0] CFG_KIND_SECOND = 2'd1;

    localparam logic [4:0] KIND_FIRST_RESET  = 5'd13;
    localparam logic [4:0] KIND_SECOND_RESET = 5'd14;

    // priority sits in the lowest bits, as on the stream bus
    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] key;
        logic [4:0]  kind;
        logic [31:0] ts;
        logic [1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic ins_cmp;
        logic ins_apply;
        logic pop_apply;
        logic can_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       cancel_done;
        logic       out_free;
    } stat_t;

    function automatic logic [FIELD5_W-1:0] to_field5(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD5_W-1:0] w;
        w = {{FIELD5_W{1'b0}}, v};
        return w[FIELD5_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/priority_task_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sorted task queue (16 entries, smaller priority first, then earlier
// timestamp, ties in arrival order). One request at a time, one response per
// request. An insert compares against all slots in parallel, then does one
// shift; a pop takes the head; a cancel runs a compaction loop over the N
// occupied entries, examining one entry per cycle. Unused mode, refused
// insert and empty pop go straight to the response. A new request is taken
// the cycle after the response is loaded into the output register, even if
// it is still unread.
module priority_task_queue_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] task_priority, [33:2] task_time, [38:34] task_kind,
    // [54:39] node_key, [62:55] task_tag, [63] zero
    input  wire logic [63:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] out_priority, [33:2] out_time, [38:34] out_kind, [54:39] out_key,
    // [62:55] out_tag, [67:63] removed_count, [72:68] occupancy, [79:73] zero
    output logic [79:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_wdata
);

    ptq_pkg::cmd_t  cmd;
    ptq_pkg::stat_t stat;

    ptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ----- design/ptq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptq_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptq_pkg::cmd_t         cmd,
    output ptq_pkg::stat_t             stat,
    input  wire logic [63:0]           s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [79:0]                m_tdata,
    output logic [1:0]                 m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [4:0]            cfg_wdata
);

    localparam int D = ptq_pkg::QUEUE_DEPTH;

    ptq_pkg::entry_t              slot_reg [D];
    ptq_pkg::entry_t              slot_next [D];
    logic [ptq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ptq_pkg::CNT_W-1:0]    remaining_reg;
    logic [ptq_pkg::CNT_W-1:0]    removed_reg;
    logic [D-1:0]                 stay_reg;
    ptq_pkg::entry_t              in_reg;
    logic [1:0]                   mode_reg;
    logic [1:0]                   status_reg;
    ptq_pkg::entry_t              popped_reg;
    logic [4:0]                   kind_first_reg, kind_second_reg;

    logic                         out_valid_reg;
    logic [72:0]                  out_data_reg;
    logic [1:0]                   out_status_reg;

    ptq_pkg::entry_t              head;
    logic                         head_hit;
    logic [ptq_pkg::CNT_W-1:0]    last_pos;
    logic [ptq_pkg::IDX_W-1:0]    last_idx;
    logic                         full, empty;

    assign full     = (count_reg == ptq_pkg::CNT_W'(D));
    assign empty    = (count_reg == '0);
    assign head     = slot_reg[0];
    assign head_hit = ((head.kind == kind_first_reg) || (head.kind == kind_second_reg))
                      && (head.key == in_reg.key);
    assign last_pos = count_reg - ptq_pkg::CNT_W'(1);
    assign last_idx = last_pos[ptq_pkg::IDX_W-1:0];

    assign stat.mode        = mode_reg;
    assign stat.full        = full;
    assign stat.empty       = empty;
    assign stat.cancel_done = (remaining_reg == '0);
    assign stat.out_free    = !out_valid_reg || m_tready;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        count_next = count_reg;
        if (cmd.ins_apply)
        begin
            for (int i = 0; i < D; i++)
            begin
                if (stay_reg[i])
                begin
                    slot_next[i] = slot_reg[i];
                end
                else if (i == 0)
                begin
                    slot_next[i] = in_reg;
                end
                else if (stay_reg[(i == 0) ? 0 : i - 1])
                begin
                    slot_next[i] = in_reg;
                end
                else
                begin
                    slot_next[i] = slot_reg[(i == 0) ? 0 : i - 1];
                end
            end
            count_next = count_reg + ptq_pkg::CNT_W'(1);
        end
        else if (cmd.pop_apply || cmd.can_step)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            if (cmd.pop_apply || head_hit)
            begin
                count_next = count_reg - ptq_pkg::CNT_W'(1);
            end
            else
            begin
                // kept entry rotates to the tail of the live region
                for (int i = 0; i < D; i++)
                begin
                    if (ptq_pkg::IDX_W'(i) == last_idx)
                    begin
                        slot_next[i] = head;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < D; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
        if (cmd.load)
        begin
            in_reg <= ptq_pkg::entry_t'(s_tdata[62:0]);
        end
        if (cmd.ins_cmp)
        begin
            for (int i = 0; i < D; i++)
            begin
                stay_reg[i] <= (ptq_pkg::CNT_W'(i) < count_reg) &&
                               !((in_reg.prio < slot_reg[i].prio) ||
                                 ((in_reg.prio == slot_reg[i].prio) &&
                                  (in_reg.ts < slot_reg[i].ts)));
            end
        end
        if (cmd.decode)
        begin
            popped_reg    <= '0;
            removed_reg   <= '0;
            remaining_reg <= count_reg;
            if ((mode_reg == ptq_pkg::MODE_INSERT) && full)
            begin
                status_reg <= ptq_pkg::STATUS_FULL;
            end
            else if ((mode_reg == ptq_pkg::MODE_POP) && empty)
            begin
                status_reg <= ptq_pkg::STATUS_EMPTY;
            end
            else
            begin
                status_reg <= ptq_pkg::STATUS_OK;
            end
        end
        if (cmd.pop_apply)
        begin
            popped_reg <= head;
        end
        if (cmd.can_step)
        begin
            remaining_reg <= remaining_reg - ptq_pkg::CNT_W'(1);
            if (head_hit)
            begin
                removed_reg <= removed_reg + ptq_pkg::CNT_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg   <= {ptq_pkg::to_field5(count_reg),
                               ptq_pkg::to_field5(removed_reg), popped_reg};
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            mode_reg        <= ptq_pkg::MODE_INSERT;
            kind_first_reg  <= ptq_pkg::KIND_FIRST_RESET;
            kind_second_reg <= ptq_pkg::KIND_SECOND_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                mode_reg <= s_tuser;
            end
            if (cfg_we && (cfg_index == ptq_pkg::CFG_KIND_FIRST))
            begin
                kind_first_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == ptq_pkg::CFG_KIND_SECOND))
            begin
                kind_second_reg <= cfg_wdata;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ----- design/ptq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ptq_pkg::stat_t stat,
    output ptq_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        INS_CMP,
        INS_APPLY,
        POP,
        CAN_STEP,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.load   = s_tvalid && ready_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = DECODE;
                end
            end
            DECODE:
            begin
                cmd.decode = 1'b1;
                if ((stat.mode == ptq_pkg::MODE_INSERT) && !stat.full)
                begin
                    state_next = INS_CMP;
                end
                else if ((stat.mode == ptq_pkg::MODE_POP) && !stat.empty)
                begin
                    state_next = POP;
                end
                else if (stat.mode == ptq_pkg::MODE_CANCEL)
                begin
                    state_next = CAN_STEP;
                end
                else
                begin
                    state_next = FINISH;
                end
            end
            INS_CMP:
            begin
                cmd.ins_cmp = 1'b1;
                state_next  = INS_APPLY;
            end
            INS_APPLY:
            begin
                cmd.ins_apply = 1'b1;
                state_next    = FINISH;
            end
            POP:
            begin
                cmd.pop_apply = 1'b1;
                state_next    = FINISH;
            end
            CAN_STEP:
            begin
                if (stat.cancel_done)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    cmd.can_step = 1'b1;
                end
            end
            FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

// ----- sim/priority_task_queue_unit_tb.sv -----
`timescale 1ns / 1ps

module priority_task_queue_unit_tb;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_ITEMS   = 315;

    typedef struct packed {
        logic [1:0]      status;
        ptq_pkg::entry_t ent;
        logic [4:0]      removed;
        logic [4:0]      occ;
    } resp_t;

    typedef struct packed {
        logic [1:0]      mode;
        ptq_pkg::entry_t ent;
        logic            typed;
        resp_t           resp;
    } step_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_wdata = '0;

    // sorted queue as the block should hold it
    ptq_pkg::entry_t model_slots [ptq_pkg::QUEUE_DEPTH];
    int          model_count  = 0;
    logic [4:0]  model_kind_a = ptq_pkg::KIND_FIRST_RESET;
    logic [4:0]  model_kind_b = ptq_pkg::KIND_SECOND_RESET;

    resp_t       due_responses [$];
    step_row_t   dir_rows [$];
    logic [15:0] key_pool [3] = '{16'h1234, 16'h0000, 16'hffff};

    int          errors     = 0;
    int          n_insert   = 0;
    int          n_pop      = 0;
    int          n_cancel   = 0;
    int          n_unused   = 0;
    int          n_full     = 0;
    int          n_empty    = 0;
    int          n_removed  = 0;
    int          n_checked  = 0;
    int          tready_hold_cycles = 0;
    bit          send_burst = 1'b0;
    bit          spare_sel  = 1'b0;

    priority_task_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic resp_t queue_apply(input logic [1:0] mode, input ptq_pkg::entry_t e);
        resp_t r;
        int    pos;
        int    keep;
        int    hits;
        int    i;
        r = '0;
        case (mode)
            ptq_pkg::MODE_INSERT:
            begin
                n_insert++;
                if (model_count >= ptq_pkg::QUEUE_DEPTH)
                begin
                    r.status = ptq_pkg::STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    // goes after everything not served later than it
                    pos = 0;
                    while (pos < model_count &&
                           !(e.prio < model_slots[pos].prio ||
                             (e.prio == model_slots[pos].prio && e.ts < model_slots[pos].ts)))
                        pos++;
                    for (i = model_count; i > pos; i--)
                        model_slots[i] = model_slots[i - 1];
                    model_slots[pos] = e;
                    model_count++;
                end
            end
            ptq_pkg::MODE_POP:
            begin
                n_pop++;
                if (model_count == 0)
                begin
                    r.status = ptq_pkg::STATUS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.ent = model_slots[0];
                    for (i = 1; i < model_count; i++)
                        model_slots[i - 1] = model_slots[i];
                    model_count--;
                end
            end
            ptq_pkg::MODE_CANCEL:
            begin
                n_cancel++;
                keep = 0;
                hits = 0;
                for (i = 0; i < model_count; i++)
                begin
                    if ((model_slots[i].kind == model_kind_a ||
                         model_slots[i].kind == model_kind_b) &&
                        model_slots[i].key == e.key)
                        hits++;
                    else
                    begin
                        model_slots[keep] = model_slots[i];
                        keep++;
                    end
                end
                model_count = keep;
                n_removed += hits;
                r.removed = 5'(hits);
            end
            default:
                n_unused++;
        endcase
        r.occ = 5'(model_count);
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [1:0] prio,
                                    input logic [31:0] ts, input logic [4:0] kind,
                                    input logic [15:0] key, input logic [7:0] tag,
                                    input logic typed, input logic [1:0] st,
                                    input logic [4:0] rem, input logic [4:0] occ);
        step_row_t row;
        row            = '0;
        row.mode       = mode;
        row.ent.prio   = prio;
        row.ent.ts     = ts;
        row.ent.kind   = kind;
        row.ent.key    = key;
        row.ent.tag    = tag;
        row.typed      = typed;
        row.resp.status  = st;
        row.resp.removed = rem;
        row.resp.occ     = occ;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
            errors++;
        end
    endtask

    task automatic send_step(input logic [1:0] mode, input ptq_pkg::entry_t e,
                             input logic typed, input resp_t typed_resp);
        int unsigned gap;
        resp_t       r;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, e};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        r = queue_apply(mode, e);
        due_responses.insert(due_responses.size(), typed ? typed_resp : r);
    endtask

    task automatic send_random(input int ins_pct);
        ptq_pkg::entry_t e;
        logic [1:0]      mode;
        int              r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            mode = ptq_pkg::MODE_INSERT;
        else if (r < ins_pct + 3)
            mode = MODE_UNUSED;
        else if (r < ins_pct + 3 + (97 - ins_pct) * 2 / 3)
            mode = ptq_pkg::MODE_POP;
        else
            mode = ptq_pkg::MODE_CANCEL;
        e.prio = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0, 1:    e.ts = $urandom_range(0, 7);
            2:       e.ts = $urandom();
            default: e.ts = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        endcase
        case ($urandom_range(0, 3))
            0:       e.kind = model_kind_a;
            1:       e.kind = model_kind_b;
            default: e.kind = 5'($urandom_range(0, 31));
        endcase
        e.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 2)] : 16'($urandom());
        e.tag = 8'($urandom());
        send_step(mode, e, 1'b0, '0);
    endtask

    // lets the queue drain so the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_cancel_kinds(input logic [4:0] a, input logic [4:0] b);
        cfg_we    <= 1'b1;
        cfg_index <= ptq_pkg::CFG_KIND_FIRST;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_index <= ptq_pkg::CFG_KIND_SECOND;
        cfg_wdata <= b;
        @(posedge clk);
        // out-of-range index, must be ignored
        cfg_index <= {1'b1, spare_sel};
        cfg_wdata <= 5'($urandom());
        spare_sel = ~spare_sel;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_kind_a = a;
        model_kind_b = b;
    endtask

    task automatic run_phase(input int items);
        int i;
        int ins_pct;
        key_pool[0] = 16'($urandom());
        key_pool[1] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        key_pool[2] = 16'($urandom());
        ins_pct = 75;
        for (i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
            begin
                ins_pct    = ((i / 40) % 2) ? 30 : 75;
                send_burst = ($urandom_range(0, 3) == 0);
            end
            send_random(ins_pct);
        end
        settle();
    endtask

    initial
    begin
        logic [63:0] noise;
        int          k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(ptq_pkg::MODE_POP, 2'd3, 32'hffff_ffff, 5'd31, 16'hffff, 8'hff,
                1'b1, ptq_pkg::STATUS_EMPTY, 5'd0, 5'd0);
        add_row(MODE_UNUSED, 2'd0, 32'h0, 5'd0, 16'h0000, 8'h00,
                1'b1, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_CANCEL, 2'd0, 32'h0, 5'd13, 16'h0000, 8'h00,
                1'b1, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd3, 32'hffff_ffff, 5'd31, 16'hffff, 8'hff,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd0, 32'h0, 5'd0, 16'h0000, 8'h00,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd1, 32'd5, 5'd13, 16'h1234, 8'h01,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd1, 32'd5, 5'd14, 16'h1234, 8'h02,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd1, 32'd4, 5'd13, 16'h1234, 8'h03,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd1, 32'd5, 5'd13, 16'h1235, 8'h04,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd1, 32'd5, 5'd12, 16'h1234, 8'h05,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd0, 32'hffff_ffff, 5'd13, 16'h1234, 8'h06,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(MODE_UNUSED, 2'd3, 32'hffff_ffff, 5'd31, 16'hffff, 8'hff,
                1'b1, ptq_pkg::STATUS_OK, 5'd0, 5'd8);
        add_row(ptq_pkg::MODE_CANCEL, 2'd3, 32'hffff_ffff, 5'd13, 16'h9999, 8'hff,
                1'b1, ptq_pkg::STATUS_OK, 5'd0, 5'd8);
        add_row(ptq_pkg::MODE_CANCEL, 2'd0, 32'h0, 5'd0, 16'h1234, 8'h00,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_INSERT, 2'd2, 32'h8000_0000, 5'd14, 16'hffff, 8'h07,
                1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        for (k = 0; k < 5; k++)
            add_row(ptq_pkg::MODE_POP, 2'd0, 32'h0, 5'd0, 16'h0000, 8'h00,
                    1'b0, ptq_pkg::STATUS_OK, 5'd0, 5'd0);
        add_row(ptq_pkg::MODE_POP, 2'd3, 32'hffff_ffff, 5'd31, 16'hffff, 8'hff,
                1'b1, ptq_pkg::STATUS_EMPTY, 5'd0, 5'd0);

        for (k = 0; k < dir_rows.size(); k++)
            send_step(dir_rows[k].mode, dir_rows[k].ent, dir_rows[k].typed, dir_rows[k].resp);
        settle();

        // output held off while inserts pile up past full, then drain past empty
        tready_hold_cycles = HOLD_CYCLES;
        send_burst = 1'b1;
        for (k = 0; k < ptq_pkg::QUEUE_DEPTH + 2; k++)
            send_random(100);
        for (k = 0; k < ptq_pkg::QUEUE_DEPTH + 2; k++)
        begin
            noise = {$urandom(), $urandom()};
            send_step(ptq_pkg::MODE_POP, noise[62:0], 1'b0, '0);
        end
        settle();

        run_phase(PHASE_ITEMS);
        set_cancel_kinds(5'd0, 5'd31);
        run_phase(PHASE_ITEMS);
        set_cancel_kinds(5'd31, 5'd0);
        run_phase(PHASE_ITEMS);
        set_cancel_kinds(5'd9, 5'd9);
        run_phase(PHASE_ITEMS);
        set_cancel_kinds(5'd31, 5'd31);
        run_phase(PHASE_ITEMS);
        set_cancel_kinds(5'($urandom()), 5'($urandom()));
        run_phase(PHASE_ITEMS);

        $display("Covered %0d requests: %0d inserts, %0d pops, %0d cancels, %0d unused mode,",
                 n_insert + n_pop + n_cancel + n_unused, n_insert, n_pop, n_cancel, n_unused);
        $display("six cancel-kind settings; full refusals %0d, empty pops %0d, cancelled %0d",
                 n_full, n_empty, n_removed);
        $display("Responses checked %0d", n_checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned     gap;
        int              served;
        bit              burst;
        resp_t           want;
        ptq_pkg::entry_t got;
        served = 0;
        burst  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (served % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 17);
            if (tready_hold_cycles > 0)
            begin
                gap = tready_hold_cycles;
                tready_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            served++;
            if (due_responses.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, got status %0h data %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = due_responses[0];
                due_responses.delete(0);
                got  = m_tdata[62:0];
                n_checked++;
                check_field("status",    32'(want.status),   32'(m_tuser));
                check_field("priority",  32'(want.ent.prio), 32'(got.prio));
                check_field("time",      want.ent.ts,        got.ts);
                check_field("kind",      32'(want.ent.kind), 32'(got.kind));
                check_field("key",       32'(want.ent.key),  32'(got.key));
                check_field("tag",       32'(want.ent.tag),  32'(got.tag));
                check_field("removed",   32'(want.removed),  32'(m_tdata[67:63]));
                check_field("occupancy", 32'(want.occ),      32'(m_tdata[72:68]));
            end
        end
    end

    initial
    begin
        #2_500_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ptq_pkg.sv
design/ptq_datapath.sv
design/ptq_ctrl.sv
design/priority_task_queue_unit.sv
sim/priority_task_queue_unit_tb.sv
